// File: sv/dfs_pkg.sv
// Package of shared types and constants for the delimited field splitter.
`default_nettype none

package dfs_pkg;

   // Default field limit of a record.
   localparam int FIELD_LIMIT_DEF = 64;

   // Fixed byte constants and field widths.
   localparam logic [7:0] NEWLINE_BYTE   = 8'd10;
   localparam logic [7:0] SEPARATOR_RST  = 8'd44;
   localparam logic [7:0] QUOTE_RST      = 8'd0;
   localparam logic [7:0] ESCAPE_RST     = 8'd92;
   localparam int         FIELD_NUM_W    = 6;

   // Configuration register indexes.
   localparam int         CSR_INDEX_W    = 2;
   localparam logic [1:0] CSR_SEPARATOR  = 2'd0;
   localparam logic [1:0] CSR_QUOTE      = 2'd1;
   localparam logic [1:0] CSR_ESCAPE     = 2'd2;

   // Quote phase codes.
   localparam logic [1:0] QP_UNQUOTED    = 2'd0;
   localparam logic [1:0] QP_INSIDE      = 2'd1;
   localparam logic [1:0] QP_CLOSED      = 2'd2;

   typedef struct packed {
      logic [7:0] separator_char;
      logic [7:0] quote_char;
      logic [7:0] escape_char;
   } cfg_type;

   typedef struct packed {
      logic [1:0] quote_phase;
      logic       escape_pending;
      logic       quote_pending;
      logic       record_started;
      logic       overflow_seen;
   } flags_type;

   typedef struct packed {
      logic [7:0]             out_byte;
      logic                   byte_valid;
      logic [FIELD_NUM_W-1:0] field_number;
      logic                   field_end;
      logic                   record_end;
      logic                   field_overflow;
   } rsp_type;

endpackage

`default_nettype wire

// File: sv/dfs_cfg.sv
// Configuration registers of the delimited field splitter.
`default_nettype none

module dfs_cfg (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [dfs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [7:0]                       csr_wr_data,
   output dfs_pkg::cfg_type                      cfg
);

   dfs_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.separator_char <= dfs_pkg::SEPARATOR_RST;
         cfg_ff.quote_char     <= dfs_pkg::QUOTE_RST;
         cfg_ff.escape_char    <= dfs_pkg::ESCAPE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            dfs_pkg::CSR_SEPARATOR: cfg_ff.separator_char <= csr_wr_data;
            dfs_pkg::CSR_QUOTE:     cfg_ff.quote_char     <= csr_wr_data;
            dfs_pkg::CSR_ESCAPE:    cfg_ff.escape_char    <= csr_wr_data;
            default: begin
               // Writes to unused indexes are ignored.
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: sv/dfs_parse.sv
// Combinational parser step: next record state and result for one byte.
`default_nettype none

module dfs_parse #(
   parameter int FIELD_LIMIT = dfs_pkg::FIELD_LIMIT_DEF,
   localparam int IDX_W      = $clog2(FIELD_LIMIT + 1)
) (
   input  wire dfs_pkg::cfg_type   cfg,
   input  wire logic [7:0]         in_byte,
   input  wire logic               stream_end,
   input  wire dfs_pkg::flags_type flags,
   input  wire logic [IDX_W-1:0]   field_index,
   output dfs_pkg::flags_type      flags_in,
   output logic [IDX_W-1:0]        field_index_in,
   output logic                    rsp_hit,
   output dfs_pkg::rsp_type        rsp
);

   localparam logic [IDX_W-1:0] LIMIT      = IDX_W'(FIELD_LIMIT);
   localparam logic [IDX_W-1:0] LIMIT_LAST = IDX_W'(FIELD_LIMIT - 1);

   logic             is_quote;
   logic             done;
   logic             content;
   logic             is_sep;
   logic             is_nl;
   logic [1:0]       phase;
   logic             in_range;
   logic             do_close;
   logic             close_byte;
   logic [IDX_W-1:0] close_idx;
   logic             close_ovf;
   logic             do_clear;
   logic             emit_byte;
   logic             emit_fend;
   logic [IDX_W-1:0] num_idx;
   logic             close_in_range;
   logic [IDX_W+5:0] num_ext;

   always_comb begin
      flags_in       = flags;
      field_index_in = field_index;
      content        = 1'b0;
      is_sep         = 1'b0;
      is_nl          = 1'b0;
      done           = 1'b0;
      is_quote       = (cfg.quote_char != 8'd0) && (in_byte == cfg.quote_char);
      phase          = (flags.quote_phase > dfs_pkg::QP_CLOSED) ? dfs_pkg::QP_CLOSED
                                                                : flags.quote_phase;
      in_range       = field_index < LIMIT;

      // Byte classification.
      if (flags.escape_pending) begin
         flags_in.escape_pending = 1'b0;
         flags_in.record_started = 1'b1;
         content                 = 1'b1;
      end else if (in_byte == dfs_pkg::NEWLINE_BYTE) begin
         is_nl = 1'b1;
      end else begin
         flags_in.record_started = 1'b1;
         if (flags.quote_pending) begin
            flags_in.quote_pending = 1'b0;
            if (is_quote) begin
               content = 1'b1;
               done    = 1'b1;
            end else begin
               phase = dfs_pkg::QP_CLOSED;
            end
         end
         if (!done) begin
            if (is_quote) begin
               if (phase == dfs_pkg::QP_UNQUOTED) begin
                  phase = dfs_pkg::QP_INSIDE;
               end else if (phase == dfs_pkg::QP_INSIDE) begin
                  if (cfg.quote_char == cfg.escape_char) begin
                     flags_in.quote_pending = 1'b1;
                  end else begin
                     phase = dfs_pkg::QP_CLOSED;
                  end
               end
            end else if (in_byte == cfg.escape_char) begin
               flags_in.escape_pending = 1'b1;
            end else if (in_byte == cfg.separator_char) begin
               if (phase == dfs_pkg::QP_INSIDE) begin
                  content = 1'b1;
               end else begin
                  is_sep = 1'b1;
               end
            end else begin
               content = 1'b1;
            end
         end
      end
      flags_in.quote_phase = phase;

      // Result selection.
      do_close   = 1'b0;
      close_byte = 1'b0;
      close_idx  = field_index;
      close_ovf  = flags.overflow_seen;
      do_clear   = 1'b0;
      emit_byte  = 1'b0;
      emit_fend  = 1'b0;

      if (is_nl) begin
         do_close = flags.record_started;
         do_clear = 1'b1;
      end else if (is_sep) begin
         if (in_range) begin
            field_index_in = field_index + IDX_W'(1);
            if (field_index_in >= LIMIT) begin
               flags_in.overflow_seen = 1'b1;
            end
         end
         flags_in.quote_phase   = dfs_pkg::QP_UNQUOTED;
         flags_in.quote_pending = 1'b0;
         if (stream_end) begin
            do_close  = 1'b1;
            do_clear  = 1'b1;
            close_idx = field_index_in;
            close_ovf = flags_in.overflow_seen;
         end else begin
            emit_fend = in_range;
         end
      end else if (stream_end) begin
         do_close   = flags_in.record_started;
         close_byte = content;
         do_clear   = 1'b1;
      end else begin
         emit_byte = content && in_range;
      end

      if (do_clear) begin
         flags_in.quote_phase    = dfs_pkg::QP_UNQUOTED;
         flags_in.escape_pending = 1'b0;
         flags_in.quote_pending  = 1'b0;
         flags_in.record_started = 1'b0;
         flags_in.overflow_seen  = 1'b0;
         field_index_in          = '0;
      end

      close_in_range = close_idx < LIMIT;
      if (do_close) begin
         num_idx = close_in_range ? close_idx : LIMIT_LAST;
      end else begin
         num_idx = field_index;
      end
      num_ext = {6'd0, num_idx};

      rsp_hit            = do_close || emit_byte || emit_fend;
      rsp.byte_valid     = (do_close && close_byte && close_in_range) || emit_byte;
      rsp.out_byte       = rsp.byte_valid ? in_byte : 8'd0;
      rsp.field_number   = num_ext[5:0];
      rsp.field_end      = (do_close && close_in_range) || emit_fend;
      rsp.record_end     = do_close;
      rsp.field_overflow = do_close && close_ovf;
   end

endmodule

`default_nettype wire

// File: sv/delimited_field_splitter_core.sv
// Top level of the delimited field splitter: input register, parser step and result register.
// An accepted byte moves from the input register via the parser step to the result register.
// Throughput: one byte per cycle while rsp_stall is low, whether or not it produces a result
// transaction. The rate is set by the record state update in the parser step.
// Reset is synchronous and active high; it clears the record state, both valid flags and
// restores the configuration registers to separator comma, quoting off and escape backslash.
`default_nettype none

module delimited_field_splitter_core #(
   parameter int FIELD_LIMIT = dfs_pkg::FIELD_LIMIT_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Input channel.
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_in_byte,
   input  wire logic                             req_stream_end,
   // Result channel.
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [7:0]                            rsp_out_byte,
   output logic                                  rsp_byte_valid,
   output logic [dfs_pkg::FIELD_NUM_W-1:0]       rsp_field_number,
   output logic                                  rsp_field_end,
   output logic                                  rsp_record_end,
   output logic                                  rsp_field_overflow,
   // Configuration port.
   input  wire logic                             csr_wr_en,
   input  wire logic [dfs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [7:0]                       csr_wr_data
);

   localparam int IDX_W = $clog2(FIELD_LIMIT + 1);

   // Configuration registers.
   dfs_pkg::cfg_type cfg;

   dfs_cfg u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // Input register. It holds one accepted transaction until the result
   // register can take whatever that byte produces.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // Record state carried from byte to byte.
   dfs_pkg::flags_type flags_ff;
   dfs_pkg::flags_type flags_in;
   logic [IDX_W-1:0]   field_index_ff;
   logic [IDX_W-1:0]   field_index_in;

   // Result register.
   logic             out_valid_ff;
   dfs_pkg::rsp_type out_ff;
   dfs_pkg::rsp_type rsp_in;
   logic             rsp_hit;

   // The pipeline moves whenever the result register is empty or being
   // taken. A byte that produces no result still moves on, so it never
   // blocks the one behind it.
   logic advance;
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   dfs_parse #(
      .FIELD_LIMIT (FIELD_LIMIT)
   ) u_parse (
      .cfg            (cfg),
      .in_byte        (in_byte_ff),
      .stream_end     (in_end_ff),
      .flags          (flags_ff),
      .field_index    (field_index_ff),
      .flags_in       (flags_in),
      .field_index_in (field_index_in),
      .rsp_hit        (rsp_hit),
      .rsp            (rsp_in)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         flags_ff       <= '0;
         field_index_ff <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff && rsp_hit;
            if (in_valid_ff) begin
               flags_ff       <= flags_in;
               field_index_ff <= field_index_in;
            end
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_in_byte;
         in_end_ff  <= req_stream_end;
      end
      if (advance && in_valid_ff) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_byte       = out_ff.out_byte;
   assign rsp_byte_valid     = out_ff.byte_valid;
   assign rsp_field_number   = out_ff.field_number;
   assign rsp_field_end      = out_ff.field_end;
   assign rsp_record_end     = out_ff.record_end;
   assign rsp_field_overflow = out_ff.field_overflow;

endmodule

`default_nettype wire

// File: sv/dfs_checker.sv
// Port-level checker for the delimited field splitter, bound to the top level.
`default_nettype none

module dfs_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [7:0]                       rsp_out_byte,
   input wire logic                             rsp_byte_valid,
   input wire logic [dfs_pkg::FIELD_NUM_W-1:0]  rsp_field_number,
   input wire logic                             rsp_field_end,
   input wire logic                             rsp_record_end,
   input wire logic                             rsp_field_overflow
);

   // Overflow is only reported when the record closes.
   a_ovf_on_record_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_field_overflow |-> rsp_record_end)
      else $error("field overflow outside a record end");

   // An overflowed record end carries neither a field end nor a byte.
   a_ovf_no_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_field_overflow |-> !rsp_field_end && !rsp_byte_valid)
      else $error("overflowed record end carries field data");

   // A result that does not close a record is either a byte or a field end.
   a_mid_record_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_record_end |-> rsp_byte_valid != rsp_field_end)
      else $error("mid-record result is neither a byte nor a field end alone");

   // The byte lane reads as zero when it carries no content.
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_out_byte == 8'd0)
      else $error("out byte not zero without byte valid");

   // A stalled result transaction stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_field_number) && $stable(rsp_record_end))
      else $error("stalled result transaction changed");

endmodule

bind delimited_field_splitter_core dfs_checker u_dfs_checker (.*);

`default_nettype wire
